>>> rtl/fke_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Flow key extractor package
// Beat types, protocol codes and result kind codes shared by the extractor
// modules.
// ----------------------------------------------------------------------------
package fke_pkg;

  // Input beat: one packet byte in wire order.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } fke_in_t;

  // Output beat: one flow key per packet.
  typedef struct packed {
    logic [63:0] flow_key;
    logic [2:0]  key_kind;
    logic        truncated;
  } fke_out_t;

  // Result handed from the parser to the output buffer.
  typedef struct packed {
    logic     valid;
    fke_out_t data;
  } fke_res_t;

  localparam int unsigned MaxLabelsDef = 5;

  // Byte position within the packet and offset within a layer.
  localparam int unsigned PosW = 7;
  localparam int unsigned RelW = 6;

  // Output buffer depth.
  localparam int unsigned OutDepth = 2;
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  localparam logic [15:0] TypeIp4  = 16'h0800;
  localparam logic [15:0] TypeIp6  = 16'h86DD;
  localparam logic [15:0] TypeMpls = 16'h8847;
  localparam logic [15:0] TypeVlan = 16'h8100;
  localparam logic [15:0] TypeQinq = 16'h88A8;

  localparam logic [3:0] VerIp4 = 4'd4;
  localparam logic [3:0] VerIp6 = 4'd6;

  localparam logic [2:0] KindIp4   = 3'd0;
  localparam logic [2:0] KindIp6   = 3'd1;
  localparam logic [2:0] KindLabel = 3'd2;
  localparam logic [2:0] KindEtype = 3'd3;
  localparam logic [2:0] KindNone  = 3'd4;

  localparam logic [31:0] BosBitNet    = 32'h0000_0100;
  localparam logic [31:0] LabelBitsNet = 32'hFFFF_F000;

  localparam int unsigned Ip6Rot1 = 13;
  localparam int unsigned Ip6Rot2 = 26;
  localparam int unsigned Ip6Rot3 = 39;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // Label words are held in little-endian load order.
  localparam logic [31:0] BosMaskLe   = swap32(BosBitNet);
  localparam logic [31:0] LabelMaskLe = swap32(LabelBitsNet);

endpackage
`default_nettype wire

>>> rtl/fke_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Flow key parser
// Walks Ethernet, VLAN tags, MPLS labels and the IP header one byte per beat
// and folds the key as the bytes pass. On the last byte it gives the key,
// completing any unfinished parse as if the missing bytes were zero.
// ----------------------------------------------------------------------------
module fke_parser import fke_pkg::*; #(
  parameter int unsigned MaxLabels = MaxLabelsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     beat_valid_i,
  input  fke_in_t  beat_i,
  output fke_res_t res_o
);

  localparam int unsigned    LblW    = (MaxLabels > 1) ? $clog2(MaxLabels) : 1;
  localparam logic [LblW-1:0] LastLbl = LblW'(MaxLabels - 1);

  localparam logic [PosW-1:0] EthTypeOff  = PosW'(12);
  localparam logic [PosW-1:0] Tag1TypeOff = PosW'(16);
  localparam logic [PosW-1:0] Tag2TypeOff = PosW'(20);
  localparam logic [PosW-1:0] PosMax      = '1;

  localparam logic [RelW-1:0] Ip4ProtoOff = RelW'(9);
  localparam logic [RelW-1:0] Ip4AddrOff  = RelW'(12);
  localparam logic [RelW-1:0] Ip4LastOff  = RelW'(19);
  localparam logic [RelW-1:0] Ip6NextOff  = RelW'(6);
  localparam logic [RelW-1:0] Ip6AddrOff  = RelW'(8);
  localparam logic [RelW-1:0] Ip6LastOff  = RelW'(39);

  typedef enum logic [2:0] {
    PhEth, PhTag, PhTag2, PhMpls, PhVer, PhIp4, PhIp6, PhDone
  } phase_e;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned amt);
    return (v << amt) | (v >> (64 - amt));
  endfunction

  phase_e          phase_q, phase_d, upd_phase;
  logic [PosW-1:0] pos_q, pos_d, upd_pos;
  logic [RelW-1:0] rel_q, rel_d, upd_rel;
  logic [LblW-1:0] lbl_q, lbl_d, upd_lbl;
  logic [31:0]     label_q, label_d, upd_label;
  logic [15:0]     type_q, type_d, upd_type;
  logic [63:0]     acc_q, acc_d, upd_acc;
  logic [2:0]      kind_q, kind_d, upd_kind;

  logic [7:0]      b;
  logic            eop;
  logic            disp_en;
  logic [15:0]     type_full;
  logic [31:0]     label_full;
  logic [RelW-1:0] ip4_rel, ip6_rel;
  logic [63:0]     ip4_term, ip6_byte, ip6_term;
  fke_out_t        fin;

  assign b          = beat_i.data_byte;
  assign eop        = beat_i.end_of_packet;
  assign type_full  = {type_q[15:8], b};
  assign label_full = {b, label_q[23:0]};
  assign ip4_rel    = rel_q - Ip4AddrOff;
  assign ip6_rel    = rel_q - Ip6AddrOff;
  assign ip4_term   = 64'(b) << {ip4_rel[2:0], 3'b000};
  assign ip6_byte   = 64'(b) << {rel_q[2:0], 3'b000};

  // Each address word of IPv6 is rotated by its own amount before folding.
  always_comb begin
    case (ip6_rel[4:3])
      2'd0:    ip6_term = ip6_byte;
      2'd1:    ip6_term = rotl64(ip6_byte, Ip6Rot1);
      2'd2:    ip6_term = rotl64(ip6_byte, Ip6Rot2);
      2'd3:    ip6_term = rotl64(ip6_byte, Ip6Rot3);
      default: ip6_term = ip6_byte;
    endcase
  end

  // State after folding in the current byte.
  always_comb begin
    upd_phase = phase_q;
    upd_pos   = (pos_q == PosMax) ? pos_q : pos_q + 1'b1;
    upd_rel   = rel_q;
    upd_lbl   = lbl_q;
    upd_label = label_q;
    upd_type  = type_q;
    upd_acc   = acc_q;
    upd_kind  = kind_q;
    disp_en   = 1'b0;

    case (phase_q)
      PhEth: begin
        if (pos_q == EthTypeOff) upd_type = {b, 8'h00};
        if (pos_q == EthTypeOff + 1'b1) disp_en = 1'b1;
      end
      PhTag: begin
        if (pos_q == Tag1TypeOff) upd_type = {b, 8'h00};
        if (pos_q == Tag1TypeOff + 1'b1) disp_en = 1'b1;
      end
      PhTag2: begin
        if (pos_q == Tag2TypeOff) upd_type = {b, 8'h00};
        if (pos_q == Tag2TypeOff + 1'b1) disp_en = 1'b1;
      end
      PhMpls: begin
        upd_label[{rel_q[1:0], 3'b000} +: 8] = b;
        if (rel_q[1:0] == 2'd3) begin
          upd_rel = '0;
          if (|(label_q & BosMaskLe)) begin
            upd_phase = PhVer;
          end else if (lbl_q == LastLbl) begin
            upd_phase = PhDone;
            upd_kind  = KindLabel;
            upd_acc   = {32'h0, label_full & LabelMaskLe};
          end else begin
            upd_lbl   = lbl_q + 1'b1;
            upd_label = '0;
          end
        end else begin
          upd_rel = rel_q + 1'b1;
        end
      end
      PhVer: begin
        // This byte opens the IP header, so the header offset continues at one.
        upd_rel = RelW'(1);
        upd_acc = '0;
        if (b[7:4] == VerIp4) begin
          upd_phase = PhIp4;
        end else if (b[7:4] == VerIp6) begin
          upd_phase = PhIp6;
        end else begin
          upd_phase = PhDone;
          upd_kind  = KindLabel;
          upd_acc   = {32'h0, label_q & LabelMaskLe};
        end
      end
      PhIp4: begin
        upd_rel = rel_q + 1'b1;
        if (rel_q == Ip4ProtoOff) upd_acc = acc_q ^ 64'(b);
        if (rel_q >= Ip4AddrOff && rel_q <= Ip4LastOff) upd_acc = acc_q ^ ip4_term;
        if (rel_q == Ip4LastOff) begin
          upd_phase = PhDone;
          upd_kind  = KindIp4;
        end
      end
      PhIp6: begin
        upd_rel = rel_q + 1'b1;
        if (rel_q == Ip6NextOff) upd_acc = acc_q ^ 64'(b);
        if (rel_q >= Ip6AddrOff && rel_q <= Ip6LastOff) upd_acc = acc_q ^ ip6_term;
        if (rel_q == Ip6LastOff) begin
          upd_phase = PhDone;
          upd_kind  = KindIp6;
        end
      end
      PhDone: begin
      end
      default: begin
      end
    endcase

    // A complete type field selects the next layer.
    if (disp_en) begin
      upd_type = type_full;
      upd_rel  = '0;
      upd_acc  = '0;
      if (type_full == TypeIp4) begin
        upd_phase = PhIp4;
      end else if (type_full == TypeIp6) begin
        upd_phase = PhIp6;
      end else if (type_full == TypeMpls) begin
        upd_phase = PhMpls;
        upd_lbl   = '0;
        upd_label = '0;
      end else if (phase_q == PhEth && (type_full == TypeVlan || type_full == TypeQinq)) begin
        upd_phase = PhTag;
        upd_type  = '0;
      end else if (phase_q == PhTag && type_full == TypeVlan) begin
        upd_phase = PhTag2;
        upd_type  = '0;
      end else if (phase_q == PhEth) begin
        upd_phase = PhDone;
        upd_kind  = KindNone;
      end else begin
        upd_phase = PhDone;
        upd_kind  = KindEtype;
        upd_acc   = {48'h0, b, type_q[15:8]};
      end
    end
  end

  // Key at end of packet. Any phase other than done still had bytes to read,
  // and the rest of the parse sees them as zero.
  always_comb begin
    fin.flow_key  = '0;
    fin.key_kind  = KindNone;
    fin.truncated = (upd_phase != PhDone);
    case (upd_phase)
      PhDone: begin
        fin.key_kind = upd_kind;
        fin.flow_key = upd_acc;
      end
      PhIp4: begin
        fin.key_kind = KindIp4;
        fin.flow_key = upd_acc;
      end
      PhIp6: begin
        fin.key_kind = KindIp6;
        fin.flow_key = upd_acc;
      end
      PhVer: begin
        fin.key_kind = KindLabel;
        fin.flow_key = {32'h0, upd_label & LabelMaskLe};
      end
      PhMpls: begin
        fin.key_kind = KindLabel;
        if (|(upd_label & BosMaskLe) || upd_lbl == LastLbl) begin
          fin.flow_key = {32'h0, upd_label & LabelMaskLe};
        end
      end
      PhEth, PhTag, PhTag2: begin
        if (upd_type == TypeIp4) begin
          fin.key_kind = KindIp4;
        end else if (upd_type == TypeIp6) begin
          fin.key_kind = KindIp6;
        end else if (upd_type == TypeMpls) begin
          fin.key_kind = KindLabel;
        end else if (upd_phase == PhEth) begin
          if (upd_type == TypeVlan || upd_type == TypeQinq) fin.key_kind = KindEtype;
        end else if (upd_phase == PhTag && upd_type == TypeVlan) begin
          fin.key_kind = KindEtype;
        end else begin
          fin.key_kind = KindEtype;
          fin.flow_key = {48'h0, upd_type[7:0], upd_type[15:8]};
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.valid = beat_valid_i & eop;
  assign res_o.data  = fin;

  // The last byte returns every parse register to its packet start value.
  always_comb begin
    if (eop) begin
      phase_d = PhEth;
      pos_d   = '0;
      rel_d   = '0;
      lbl_d   = '0;
      label_d = '0;
      type_d  = '0;
      acc_d   = '0;
      kind_d  = KindNone;
    end else begin
      phase_d = upd_phase;
      pos_d   = upd_pos;
      rel_d   = upd_rel;
      lbl_d   = upd_lbl;
      label_d = upd_label;
      type_d  = upd_type;
      acc_d   = upd_acc;
      kind_d  = upd_kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhEth;
      pos_q   <= '0;
      rel_q   <= '0;
      lbl_q   <= '0;
      label_q <= '0;
      type_q  <= '0;
      acc_q   <= '0;
      kind_q  <= KindNone;
    end else if (beat_valid_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      rel_q   <= rel_d;
      lbl_q   <= lbl_d;
      label_q <= label_d;
      type_q  <= type_d;
      acc_q   <= acc_d;
      kind_q  <= kind_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/fke_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Flow key output buffer
// Two-entry result queue that decouples the byte stream from a stalled
// consumer of flow keys.
// ----------------------------------------------------------------------------
module fke_out_buf import fke_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fke_res_t res_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output fke_out_t out_beat_o
);

  localparam int unsigned PtrW = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam logic [PtrW-1:0]    LastPtr = PtrW'(OutDepth - 1);
  localparam logic [OutCntW-1:0] FullCnt = OutCntW'(OutDepth);

  fke_out_t           mem_q [OutDepth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [OutCntW-1:0] cnt_q, cnt_d;
  logic               push, pop;

  assign push        = res_i.valid;
  assign pop         = out_valid_o & ~out_stall_i;
  assign full_o      = (cnt_q == FullCnt);
  assign out_valid_o = (cnt_q != '0);
  assign out_beat_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= res_i.data;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("output buffer count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full_o)
    else $error("flow key written into a full output buffer");

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("output buffer count missed a write");

  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("output buffer count missed a read");

endmodule
`default_nettype wire

>>> rtl/flow_key_extractor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Flow key extractor
// Parses L2/L3 headers from a byte stream and gives one 64-bit flow key per
// packet.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake               | Beat
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | one packet byte, end mark
//  out     | output    | out_valid_o/out_stall_i | flow key, kind, truncated flag
//
// One byte is taken every cycle while in_stall_o is low; each byte but the last
// only updates the parse registers. The key of a packet is written to a
// two-entry output queue at the clock edge that takes the last byte and is
// offered on the next cycle. in_stall_o rises only while both queue entries
// hold keys not yet taken. Reset puts the parser at the start of an Ethernet
// header and empties the queue.
// ----------------------------------------------------------------------------
module flow_key_extractor_top import fke_pkg::*; #(
  parameter int unsigned MaxLabels = MaxLabelsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  fke_in_t  in_beat_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output fke_out_t out_beat_o
);

  logic     in_take;
  logic     buf_full;
  fke_res_t res;

  assign in_stall_o = buf_full;
  assign in_take    = in_valid_i & ~buf_full;

  fke_parser #(
    .MaxLabels(MaxLabels)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_valid_i(in_take),
    .beat_i      (in_beat_i),
    .res_o       (res)
  );

  fke_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

endmodule
`default_nettype wire

>>> sim/tb_flow_key_extractor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Flow key extractor testbench
// Sends Ethernet frames byte by byte (plain, tagged, MPLS, IPv4, IPv6, short,
// long and noise frames) and checks every flow key against a predictor.
// The predictor keeps its own header window. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_flow_key_extractor_top;
  import fke_pkg::*;

  localparam int unsigned HdrLimit  = 128;
  localparam int unsigned QuietMax  = 4000;
  localparam int unsigned PhaseByte = 300;
  localparam int unsigned PhaseMinF = 5;

  // Label word as loaded little-endian: the bottom-of-stack bit is bit 0 of
  // the third wire byte, the label spans the first two bytes and a nibble.
  localparam logic [31:0] LeBosBit    = 32'h0001_0000;
  localparam logic [31:0] LeLabelBits = 32'h00F0_FFFF;

  typedef enum int {
    ENC_IP4, ENC_IP6, ENC_MPLS, ENC_VLAN, ENC_QINQ, ENC_OTHER, ENC_NOISE
  } encap_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  fke_in_t  in_beat_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  fke_out_t out_beat_o;

  flow_key_extractor_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  fke_in_t     byte_beats[$];
  fke_out_t    expected_keys[$];
  logic [7:0]  frame_buf[$];
  int          fill_byte = -1;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned phase_bytes;
  int unsigned phase_frames;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  // Predictor state: header window of the frame being received.
  logic [7:0]  hdr_win [HdrLimit];
  int unsigned hdr_len = 0;
  logic        hdr_short;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [7:0] win_byte(input int unsigned off);
    if (off >= hdr_len || off >= HdrLimit) begin
      hdr_short = 1'b1;
      return 8'h00;
    end
    return hdr_win[off];
  endfunction

  function automatic logic [15:0] win_be16(input int unsigned off);
    return {win_byte(off), win_byte(off + 1)};
  endfunction

  function automatic logic [31:0] win_le32(input int unsigned off);
    return {win_byte(off + 3), win_byte(off + 2), win_byte(off + 1), win_byte(off)};
  endfunction

  function automatic logic [63:0] win_le64(input int unsigned off);
    return {win_le32(off + 4), win_le32(off)};
  endfunction

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] ip4_key(input int unsigned o);
    return win_le64(o + 12) ^ {56'd0, win_byte(o + 9)};
  endfunction

  function automatic logic [63:0] ip6_key(input int unsigned o);
    return win_le64(o + 8) ^ rotl64(win_le64(o + 16), 13) ^
           rotl64(win_le64(o + 24), 26) ^ rotl64(win_le64(o + 32), 39) ^
           {56'd0, win_byte(o + 6)};
  endfunction

  function automatic logic [63:0] label_stack_key(input int unsigned o,
                                                  output logic [2:0] kind);
    logic [31:0] word;
    logic [7:0]  ver_byte;
    logic [3:0]  ver;
    int unsigned p;
    for (int unsigned i = 0; i < MaxLabelsDef; i++) begin
      word = win_le32(o + 4 * i);
      if ((word & LeBosBit) != 0) begin
        p = o + 4 * (i + 1);
        ver_byte = win_byte(p);
        ver = ver_byte[7:4];
        if (ver == VerIp4) begin
          kind = KindIp4;
          return ip4_key(p);
        end
        if (ver == VerIp6) begin
          kind = KindIp6;
          return ip6_key(p);
        end
        kind = KindLabel;
        return {32'd0, word & LeLabelBits};
      end
    end
    kind = KindLabel;
    return {32'd0, win_le32(o + 4 * (MaxLabelsDef - 1)) & LeLabelBits};
  endfunction

  function automatic logic [63:0] type_key(input logic [15:0] etype, input int unsigned o,
                                           output logic [2:0] kind, output logic known);
    known = 1'b1;
    kind  = KindNone;
    if (etype == TypeIp4) begin
      kind = KindIp4;
      return ip4_key(o);
    end
    if (etype == TypeIp6) begin
      kind = KindIp6;
      return ip6_key(o);
    end
    if (etype == TypeMpls) return label_stack_key(o, kind);
    known = 1'b0;
    return 64'd0;
  endfunction

  function automatic logic [63:0] frame_key(output logic [2:0] kind);
    logic [15:0] etype;
    logic [63:0] key;
    logic        known;
    int unsigned tag;
    etype = win_be16(12);
    key = type_key(etype, 14, kind, known);
    if (known) return key;
    if (etype == TypeVlan || etype == TypeQinq) begin
      tag = 14;
      if (win_be16(tag + 2) == TypeVlan) tag += 4;
      key = type_key(win_be16(tag + 2), tag + 4, kind, known);
      if (known) return key;
      // A third tag is not skipped: its type is the key, loaded little-endian.
      kind = KindEtype;
      return {48'd0, win_byte(tag + 3), win_byte(tag + 2)};
    end
    kind = KindNone;
    return 64'd0;
  endfunction

  task automatic take_byte(input fke_in_t beat);
    fke_out_t res;
    if (hdr_len < HdrLimit) begin
      hdr_win[hdr_len] = beat.data_byte;
      hdr_len++;
    end
    if (beat.end_of_packet) begin
      hdr_short = 1'b0;
      res.flow_key  = frame_key(res.key_kind);
      res.truncated = hdr_short;
      expected_keys.push_back(res);
      hdr_len = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Frame builder
  // --------------------------------------------------------------------------
  function automatic logic [7:0] fill_val();
    if (fill_byte < 0) return 8'($urandom);
    return 8'(fill_byte);
  endfunction

  task automatic put_fill(input int unsigned n);
    repeat (n) frame_buf.push_back(fill_val());
  endtask

  task automatic put16(input logic [15:0] v);
    frame_buf.push_back(v[15:8]);
    frame_buf.push_back(v[7:0]);
  endtask

  task automatic put_type(input encap_e enc);
    case (enc)
      ENC_IP4:  put16(TypeIp4);
      ENC_IP6:  put16(TypeIp6);
      ENC_MPLS: put16(TypeMpls);
      ENC_VLAN: put16(TypeVlan);
      ENC_QINQ: put16(TypeQinq);
      default:  put16(16'($urandom));
    endcase
  endtask

  task automatic put_ip(input logic [3:0] ver);
    logic [7:0] b;
    b = fill_val();
    frame_buf.push_back({ver, b[3:0]});
    put_fill(ver == VerIp6 ? 39 : 19);
  endtask

  task automatic put_labels(input int nlab, input int bos_at, input int next_ver);
    logic [7:0] b;
    for (int i = 0; i < nlab; i++) begin
      put_fill(2);
      b = fill_val();
      b[0] = (i == bos_at);
      frame_buf.push_back(b);
      put_fill(1);
    end
    if (bos_at < nlab) begin
      if (next_ver == VerIp4 || next_ver == VerIp6) begin
        put_ip(4'(next_ver));
      end else begin
        b = fill_val();
        frame_buf.push_back({4'(next_ver), b[3:0]});
        put_fill(3);
      end
    end
  endtask

  task automatic put_body(input encap_e enc, input int nlab, input int bos_at,
                          input int next_ver);
    case (enc)
      ENC_IP4:  put_ip(VerIp4);
      ENC_IP6:  put_ip(VerIp6);
      ENC_MPLS: put_labels(nlab, bos_at, next_ver);
      ENC_VLAN: begin
        put_fill(2);
        put_ip(VerIp4);
      end
      default:  put_fill(4);
    endcase
  endtask

  task automatic build_frame(input encap_e outer, input bit two_tags, input encap_e inner,
                             input int nlab, input int bos_at, input int next_ver,
                             input int tail_len, input int cut_len);
    fke_in_t beat;
    frame_buf.delete();
    if (outer == ENC_NOISE) begin
      put_fill(tail_len);
    end else begin
      put_fill(12);
      put_type(outer);
      if (outer == ENC_VLAN || outer == ENC_QINQ) begin
        put_fill(2);
        if (two_tags) begin
          put16(TypeVlan);
          put_fill(2);
        end
        put_type(inner);
        put_body(inner, nlab, bos_at, next_ver);
      end else begin
        put_body(outer, nlab, bos_at, next_ver);
      end
      put_fill(tail_len);
    end
    if (cut_len > 0) begin
      while (frame_buf.size() > cut_len) void'(frame_buf.pop_back());
    end
    foreach (frame_buf[i]) begin
      beat.data_byte     = frame_buf[i];
      beat.end_of_packet = (i == frame_buf.size() - 1);
      byte_beats.push_back(beat);
    end
    phase_bytes  += frame_buf.size();
    phase_frames += 1;
  endtask

  task automatic random_frame();
    int unsigned r;
    encap_e      outer;
    encap_e      inner;
    int          nlab;
    int          bos_at;
    int          next_ver;
    int          tail_len;
    int          cut_len;
    r = $urandom_range(99);
    outer = r < 22 ? ENC_IP4 : r < 44 ? ENC_IP6 : r < 64 ? ENC_MPLS :
            r < 76 ? ENC_VLAN : r < 86 ? ENC_QINQ : r < 93 ? ENC_OTHER : ENC_NOISE;
    r = $urandom_range(99);
    inner = r < 25 ? ENC_IP4 : r < 50 ? ENC_IP6 : r < 75 ? ENC_MPLS :
            r < 87 ? ENC_VLAN : ENC_OTHER;
    nlab   = $urandom_range(MaxLabelsDef + 1, 1);
    // A bottom index equal to the label count means no bottom label at all.
    bos_at = $urandom_range(nlab, 0);
    r = $urandom_range(9);
    if (r < 4) begin
      next_ver = VerIp4;
    end else if (r < 8) begin
      next_ver = VerIp6;
    end else begin
      do next_ver = $urandom_range(15); while (next_ver == VerIp4 || next_ver == VerIp6);
    end
    tail_len = ($urandom_range(99) < 4) ? $urandom_range(160, 60) : $urandom_range(6, 0);
    if (outer == ENC_NOISE) tail_len = $urandom_range(24, 1);
    cut_len = ($urandom_range(99) < 12) ? $urandom_range(80, 1) : 0;
    build_frame(outer, 1'($urandom_range(1)), inner, nlab, bos_at, next_ver,
                tail_len, cut_len);
  endtask

  task automatic directed_frames();
    fill_byte = 8'h00;
    build_frame(ENC_NOISE, 0, ENC_IP4, 1, 0, 4, 1, 0);
    build_frame(ENC_IP4, 0, ENC_IP4, 1, 0, 4, 0, 0);
    fill_byte = 8'hFF;
    build_frame(ENC_NOISE, 0, ENC_IP4, 1, 0, 4, 1, 0);
    build_frame(ENC_IP4, 0, ENC_IP4, 1, 0, 4, 0, 0);
    build_frame(ENC_IP6, 0, ENC_IP4, 1, 0, 4, 0, 0);
    build_frame(ENC_MPLS, 0, ENC_IP4, 3, 2, 6, 2, 0);
    fill_byte = -1;
    build_frame(ENC_IP4, 0, ENC_IP4, 1, 0, 4, 0, 15);          // short after ethertype
    build_frame(ENC_IP6, 0, ENC_IP4, 1, 0, 4, 0, 40);          // short IPv6 header
    build_frame(ENC_MPLS, 0, ENC_IP4, 1, 0, 4, 3, 0);          // bottom label, IPv4
    build_frame(ENC_MPLS, 0, ENC_IP4, 2, 1, 9, 0, 0);          // bottom label, bad version
    build_frame(ENC_MPLS, 0, ENC_IP4, MaxLabelsDef, MaxLabelsDef, 4, 4, 0);
    build_frame(ENC_MPLS, 0, ENC_IP4, MaxLabelsDef + 2, MaxLabelsDef + 1, 4, 0, 0);
    build_frame(ENC_VLAN, 0, ENC_IP6, 1, 0, 4, 0, 0);
    build_frame(ENC_QINQ, 1, ENC_MPLS, 3, 2, 6, 0, 0);
    build_frame(ENC_QINQ, 1, ENC_VLAN, 1, 0, 4, 0, 0);         // three tags
    build_frame(ENC_VLAN, 0, ENC_OTHER, 1, 0, 4, 0, 0);
    build_frame(ENC_OTHER, 0, ENC_IP4, 1, 0, 4, 3, 0);
    build_frame(ENC_IP4, 0, ENC_IP4, 1, 0, 4, 170, 0);         // beyond the window
  endtask

  // --------------------------------------------------------------------------
  // Driver: next byte goes out once the current beat is taken or none is held.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_beat_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) take_byte(in_beat_i);
      if (!in_valid_i || !in_stall_o) begin
        if (byte_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_beat_i  <= byte_beats.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    fke_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_keys.size() == 0) begin
          $display("%0t: key beat with none expected, got %h", $time, out_beat_o);
          error_count++;
        end else begin
          want = expected_keys.pop_front();
          if (out_beat_o.flow_key !== want.flow_key) begin
            $display("%0t: flow_key mismatch, expected %h, got %h",
                     $time, want.flow_key, out_beat_o.flow_key);
            error_count++;
          end
          if (out_beat_o.key_kind !== want.key_kind) begin
            $display("%0t: key_kind mismatch, expected %0d, got %0d",
                     $time, want.key_kind, out_beat_o.key_kind);
            error_count++;
          end
          if (out_beat_o.truncated !== want.truncated) begin
            $display("%0t: truncated mismatch, expected %0d, got %0d",
                     $time, want.truncated, out_beat_o.truncated);
            error_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietMax) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      phase_bytes  = 0;
      phase_frames = 0;
      if (phase == 0) directed_frames();
      while (phase_bytes < PhaseByte || phase_frames < PhaseMinF) random_frame();
      while (byte_beats.size() > 0 || in_valid_i || expected_keys.size() > 0)
        @(posedge clk_i);
    end
    repeat (16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
